/* hdl/qtef_pkg.sv */
package qtef_pkg;

  // Q16.16 value and the exact product of two of them
  typedef logic signed [31:0] fx_t;
  typedef logic signed [63:0] prod_t;

  // advance enables of the two register stages inside one pipeline module
  typedef struct packed {
    logic adv_a;
    logic adv_b;
  } stg_ctl_t;

  localparam int unsigned NUM_STAGES = 10;
  localparam int unsigned NUM_Q      = 5;
  localparam int unsigned CFG_W      = 31;
  localparam int unsigned CFG_IDX_W  = 3;

  // component slots of the five independent tensor entries
  localparam int unsigned IDX_XX = 0;
  localparam int unsigned IDX_XY = 1;
  localparam int unsigned IDX_XZ = 2;
  localparam int unsigned IDX_YY = 3;
  localparam int unsigned IDX_YZ = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L2     = 3'd4;

  localparam logic [CFG_W-1:0] CFG_RESET   = 31'd65536;
  localparam fx_t              Q_MAX       = 32'sh7fffffff;
  localparam fx_t              Q_MIN       = 32'sh80000000;
  localparam fx_t              ONE_THIRD_Q = 32'sd21845;

  // clamp a wide signed value into Q16.16
  function automatic fx_t sat32(input logic signed [65:0] v);
    if (v > 66'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < 66'(Q_MIN)) begin
      return Q_MIN;
    end
    return fx_t'(v[31:0]);
  endfunction

  // drop 16 fraction bits, rounding half up, then clamp
  function automatic fx_t fx_round(input prod_t p);
    logic signed [64:0] r;
    logic signed [48:0] sh;
    r  = 65'(p) + 65'sd32768;
    sh = 49'(r >>> 16);
    return sat32(66'(sh));
  endfunction

  // product with one half under the same rounding: floor((x+1)/2)
  function automatic fx_t half_q(input fx_t x);
    logic signed [32:0] t;
    t = 33'(x) + 33'sd1;
    return fx_t'(t[32:1]);
  endfunction

endpackage

/* hdl/qtef_front.sv */
module qtef_front import qtef_pkg::*; (
  input  logic                  clk_i,
  input  stg_ctl_t              ctl_i,
  input  logic signed [8:0]     kx_i,
  input  logic signed [8:0]     ky_i,
  input  logic signed [8:0]     kz_i,
  input  logic [CFG_W-1:0]      k_sq_i,
  input  fx_t                   q_i [NUM_Q],
  input  logic [CFG_W-1:0]      wave_x_i,
  input  logic [CFG_W-1:0]      wave_y_i,
  input  logic [CFG_W-1:0]      wave_z_i,
  input  logic [CFG_W-1:0]      l1_i,
  output fx_t                   k_o [3],
  output fx_t                   q_o [NUM_Q],
  output fx_t                   zz_o,
  output fx_t                   dmy_o
);

  logic signed [40:0] pk_d [3];
  logic signed [40:0] pk_q [3];
  logic [61:0]        pl1_d, pl1_q;
  logic signed [33:0] zsum;
  fx_t                zz1_d, zz1_q, zz2_q;
  fx_t                q1_q [NUM_Q];
  fx_t                q2_q [NUM_Q];
  fx_t                k_d [3];
  fx_t                k_q [3];
  fx_t                l1k_r, dmy_d, dmy_q;

  // stage A: wave products, L1*k2, zz entry
  always_comb begin
    pk_d[0] = kx_i * $signed({1'b0, wave_x_i});
    pk_d[1] = ky_i * $signed({1'b0, wave_y_i});
    pk_d[2] = kz_i * $signed({1'b0, wave_z_i});
    pl1_d   = l1_i * k_sq_i;
    zsum    = -(34'(q_i[IDX_XX]) + 34'(q_i[IDX_YY]));
    zz1_d   = sat32(66'(zsum));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_a) begin
      pk_q  <= pk_d;
      pl1_q <= pl1_d;
      zz1_q <= zz1_d;
      q1_q  <= q_i;
    end
  end

  // stage B: clamp the wave vector, finish -L1*k2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_d[i] = sat32(66'(pk_q[i]));
    end
    l1k_r = fx_round($signed({2'b00, pl1_q}));
    dmy_d = sat32(-66'(l1k_r));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_b) begin
      k_q   <= k_d;
      dmy_q <= dmy_d;
      zz2_q <= zz1_q;
      q2_q  <= q1_q;
    end
  end

  assign k_o   = k_q;
  assign q_o   = q2_q;
  assign zz_o  = zz2_q;
  assign dmy_o = dmy_q;

endmodule

/* hdl/qtef_div.sv */
module qtef_div import qtef_pkg::*; (
  input  logic     clk_i,
  input  stg_ctl_t ctl_i,
  input  fx_t      k_i [3],
  input  fx_t      q_i [NUM_Q],
  input  fx_t      zz_i,
  input  fx_t      dmy_i,
  output fx_t      k_o [3],
  output fx_t      d_o [3],
  output fx_t      a_o [NUM_Q]
);

  fx_t   qm [3][3];
  prod_t pd_d [3][3];
  prod_t pd_q [3][3];
  prod_t pa_d [NUM_Q];
  prod_t pa_q [NUM_Q];
  fx_t   k3_q [3];
  fx_t   k4_q [3];
  fx_t   d_d [3];
  fx_t   d_q [3];
  fx_t   a_d [NUM_Q];
  fx_t   a_q [NUM_Q];

  // stage A: products of k with each row of Q, and of -L1*k2 with Q
  always_comb begin
    qm[0][0] = q_i[IDX_XX];
    qm[0][1] = q_i[IDX_XY];
    qm[0][2] = q_i[IDX_XZ];
    qm[1][0] = q_i[IDX_XY];
    qm[1][1] = q_i[IDX_YY];
    qm[1][2] = q_i[IDX_YZ];
    qm[2][0] = q_i[IDX_XZ];
    qm[2][1] = q_i[IDX_YZ];
    qm[2][2] = zz_i;
    for (int n = 0; n < 3; n++) begin
      for (int m = 0; m < 3; m++) begin
        pd_d[n][m] = k_i[m] * qm[n][m];
      end
    end
    for (int i = 0; i < NUM_Q; i++) begin
      pa_d[i] = dmy_i * q_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_a) begin
      pd_q <= pd_d;
      pa_q <= pa_d;
      k3_q <= k_i;
    end
  end

  // stage B: round and sum the rows into the divergence
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      d_d[n] = sat32(66'(fx_round(pd_q[n][0])) + 66'(fx_round(pd_q[n][1]))
                     + 66'(fx_round(pd_q[n][2])));
    end
    for (int i = 0; i < NUM_Q; i++) begin
      a_d[i] = fx_round(pa_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_b) begin
      d_q  <= d_d;
      a_q  <= a_d;
      k4_q <= k3_q;
    end
  end

  assign k_o = k4_q;
  assign d_o = d_q;
  assign a_o = a_q;

endmodule

/* hdl/qtef_sym.sv */
module qtef_sym import qtef_pkg::*; (
  input  logic     clk_i,
  input  stg_ctl_t ctl_i,
  input  fx_t      k_i [3],
  input  fx_t      d_i [3],
  input  fx_t      a_i [NUM_Q],
  output fx_t      s_o,
  output fx_t      sv_o [NUM_Q],
  output fx_t      a_o [NUM_Q]
);

  prod_t pkd_d [3][3];
  prod_t pkd_q [3][3];
  fx_t   r [3][3];
  fx_t   a5_q [NUM_Q];
  fx_t   a6_q [NUM_Q];
  fx_t   s_d, s_q;
  fx_t   sv_d [NUM_Q];
  fx_t   sv_q [NUM_Q];

  // stage A: every k_m * d_n
  always_comb begin
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        pkd_d[m][n] = k_i[m] * d_i[n];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_a) begin
      pkd_q <= pkd_d;
      a5_q  <= a_i;
    end
  end

  // stage B: trace sum k.d, diagonal terms, halved off-diagonal sums
  always_comb begin
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        r[m][n] = fx_round(pkd_q[m][n]);
      end
    end
    s_d          = sat32(66'(r[0][0]) + 66'(r[1][1]) + 66'(r[2][2]));
    sv_d[IDX_XX] = r[0][0];
    sv_d[IDX_YY] = r[1][1];
    sv_d[IDX_XY] = half_q(sat32(66'(r[0][1]) + 66'(r[1][0])));
    sv_d[IDX_XZ] = half_q(sat32(66'(r[0][2]) + 66'(r[2][0])));
    sv_d[IDX_YZ] = half_q(sat32(66'(r[1][2]) + 66'(r[2][1])));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_b) begin
      s_q  <= s_d;
      sv_q <= sv_d;
      a6_q <= a5_q;
    end
  end

  assign s_o  = s_q;
  assign sv_o = sv_q;
  assign a_o  = a6_q;

endmodule

/* hdl/qtef_trace.sv */
module qtef_trace import qtef_pkg::*; (
  input  logic     clk_i,
  input  stg_ctl_t ctl_i,
  input  fx_t      s_i,
  input  fx_t      sv_i [NUM_Q],
  input  fx_t      a_i [NUM_Q],
  output fx_t      sv_o [NUM_Q],
  output fx_t      a_o [NUM_Q]
);

  prod_t pt_d, pt_q;
  fx_t   sv7_q [NUM_Q];
  fx_t   a7_q [NUM_Q];
  fx_t   a8_q [NUM_Q];
  fx_t   t;
  fx_t   sv_d [NUM_Q];
  fx_t   sv_q [NUM_Q];

  // stage A: divide the trace sum by three
  assign pt_d = s_i * ONE_THIRD_Q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_a) begin
      pt_q  <= pt_d;
      sv7_q <= sv_i;
      a7_q  <= a_i;
    end
  end

  // stage B: subtract the trace share from the diagonal terms
  always_comb begin
    t            = fx_round(pt_q);
    sv_d         = sv7_q;
    sv_d[IDX_XX] = sat32(66'(sv7_q[IDX_XX]) - 66'(t));
    sv_d[IDX_YY] = sat32(66'(sv7_q[IDX_YY]) - 66'(t));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_b) begin
      sv_q <= sv_d;
      a8_q <= a7_q;
    end
  end

  assign sv_o = sv_q;
  assign a_o  = a8_q;

endmodule

/* hdl/qtef_out.sv */
module qtef_out import qtef_pkg::*; (
  input  logic             clk_i,
  input  stg_ctl_t         ctl_i,
  input  fx_t              sv_i [NUM_Q],
  input  fx_t              a_i [NUM_Q],
  input  logic [CFG_W-1:0] l2_i,
  output fx_t              h_o [NUM_Q]
);

  prod_t pr_d [NUM_Q];
  prod_t pr_q [NUM_Q];
  fx_t   a9_q [NUM_Q];
  fx_t   h_d [NUM_Q];
  fx_t   h_q [NUM_Q];

  // stage A: L2 times the symmetrized term
  always_comb begin
    for (int i = 0; i < NUM_Q; i++) begin
      pr_d[i] = $signed({1'b0, l2_i}) * sv_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_a) begin
      pr_q <= pr_d;
      a9_q <= a_i;
    end
  end

  // stage B: combine into the field, this is the output register
  always_comb begin
    for (int i = 0; i < NUM_Q; i++) begin
      h_d[i] = sat32(66'(a9_q[i]) - 66'(fx_round(pr_q[i])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_b) begin
      h_q <= h_d;
    end
  end

  assign h_o = h_q;

endmodule

/* hdl/qtensor_elastic_field_kspace.sv */
// Throughput: one beat per cycle while out_ready_i is high; ten register stages,
// each holding at most one multiplier bank or one round-and-add, each with its
// own valid bit. A stalled output holds its stage; bubbles ahead of it still collapse.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets all five
// configuration registers to 1.0 in Q16.16.
module qtensor_elastic_field_kspace import qtef_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [8:0]    kx_index_i,
  input  logic signed [8:0]    ky_index_i,
  input  logic signed [8:0]    kz_index_i,
  input  logic [30:0]          k_squared_i,
  input  logic signed [31:0]   q_xx_i,
  input  logic signed [31:0]   q_xy_i,
  input  logic signed [31:0]   q_xz_i,
  input  logic signed [31:0]   q_yy_i,
  input  logic signed [31:0]   q_yz_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   h_xx_o,
  output logic signed [31:0]   h_xy_o,
  output logic signed [31:0]   h_xz_o,
  output logic signed [31:0]   h_yy_o,
  output logic signed [31:0]   h_yz_o
);

  // configuration registers
  logic [CFG_W-1:0] wave_x_q, wave_y_q, wave_z_q, l1_q, l2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_x_q <= CFG_RESET;
      wave_y_q <= CFG_RESET;
      wave_z_q <= CFG_RESET;
      l1_q     <= CFG_RESET;
      l2_q     <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAVE_X: wave_x_q <= cfg_data_i;
        REG_WAVE_Y: wave_y_q <= cfg_data_i;
        REG_WAVE_Z: wave_z_q <= cfg_data_i;
        REG_L1:     l1_q     <= cfg_data_i;
        REG_L2:     l2_q     <= cfg_data_i;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Pipeline control: a stage advances when it is empty or the stage after it
  // advances. The last stage is the output register and advances when empty or on out_ready_i.
  logic [NUM_STAGES-1:0] v_d, v_q, adv;

  always_comb begin
    adv[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
    v_d[0] = adv[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      v_d[i] = adv[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  stg_ctl_t ctl_front, ctl_div, ctl_sym, ctl_trace, ctl_out;

  assign ctl_front = '{adv_a: adv[0], adv_b: adv[1]};
  assign ctl_div   = '{adv_a: adv[2], adv_b: adv[3]};
  assign ctl_sym   = '{adv_a: adv[4], adv_b: adv[5]};
  assign ctl_trace = '{adv_a: adv[6], adv_b: adv[7]};
  assign ctl_out   = '{adv_a: adv[8], adv_b: adv[9]};

  // datapath
  fx_t q_in [NUM_Q];
  fx_t k_fr [3];
  fx_t q_fr [NUM_Q];
  fx_t zz_fr, dmy_fr;
  fx_t k_dv [3];
  fx_t d_dv [3];
  fx_t a_dv [NUM_Q];
  fx_t s_sy;
  fx_t sv_sy [NUM_Q];
  fx_t a_sy [NUM_Q];
  fx_t sv_tr [NUM_Q];
  fx_t a_tr [NUM_Q];
  fx_t h [NUM_Q];

  assign q_in[IDX_XX] = q_xx_i;
  assign q_in[IDX_XY] = q_xy_i;
  assign q_in[IDX_XZ] = q_xz_i;
  assign q_in[IDX_YY] = q_yy_i;
  assign q_in[IDX_YZ] = q_yz_i;

  // stages 1-2: wave vector k, zz entry, -L1*k2
  qtef_front u_front (
    .clk_i    (clk_i),
    .ctl_i    (ctl_front),
    .kx_i     (kx_index_i),
    .ky_i     (ky_index_i),
    .kz_i     (kz_index_i),
    .k_sq_i   (k_squared_i),
    .q_i      (q_in),
    .wave_x_i (wave_x_q),
    .wave_y_i (wave_y_q),
    .wave_z_i (wave_z_q),
    .l1_i     (l1_q),
    .k_o      (k_fr),
    .q_o      (q_fr),
    .zz_o     (zz_fr),
    .dmy_o    (dmy_fr)
  );

  // stages 3-4: divergence d = k.Q and the L1 term
  qtef_div u_div (
    .clk_i (clk_i),
    .ctl_i (ctl_div),
    .k_i   (k_fr),
    .q_i   (q_fr),
    .zz_i  (zz_fr),
    .dmy_i (dmy_fr),
    .k_o   (k_dv),
    .d_o   (d_dv),
    .a_o   (a_dv)
  );

  // stages 5-6: outer products of k and d
  qtef_sym u_sym (
    .clk_i (clk_i),
    .ctl_i (ctl_sym),
    .k_i   (k_dv),
    .d_i   (d_dv),
    .a_i   (a_dv),
    .s_o   (s_sy),
    .sv_o  (sv_sy),
    .a_o   (a_sy)
  );

  // stages 7-8: trace share k.d/3 off the diagonal terms
  qtef_trace u_trace (
    .clk_i (clk_i),
    .ctl_i (ctl_trace),
    .s_i   (s_sy),
    .sv_i  (sv_sy),
    .a_i   (a_sy),
    .sv_o  (sv_tr),
    .a_o   (a_tr)
  );

  // stages 9-10: apply L2 and combine
  qtef_out u_out (
    .clk_i (clk_i),
    .ctl_i (ctl_out),
    .sv_i  (sv_tr),
    .a_i   (a_tr),
    .l2_i  (l2_q),
    .h_o   (h)
  );

  assign h_xx_o = h[IDX_XX];
  assign h_xy_o = h[IDX_XY];
  assign h_xz_o = h[IDX_XZ];
  assign h_yy_o = h[IDX_YY];
  assign h_yz_o = h[IDX_YZ];

  // a ready sink keeps the whole pipeline moving
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // an accepted beat lands in the first stage
  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted beat lost at pipeline entry");

  // a stalled middle stage keeps its beat
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !adv[4]) |=> v_q[4])
    else $error("stalled beat dropped in middle stage");

  // a beat in the next-to-last stage moves into the output register
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NUM_STAGES-2] && adv[NUM_STAGES-1]) |=> out_valid_o)
    else $error("beat lost before output register");

endmodule
